@@ rtl/core/lwag_pkg.sv @@
package lwag_pkg;

    // default sizes, handed to the top level parameters
    localparam int LED_COUNT_DEF  = 60;
    localparam int WAVE_COUNT_DEF = 4;

    // fixed field widths
    localparam int LED_IDX_W  = 6;
    localparam int WAVE_IDX_W = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = 34;

    // length of the wait state between the last wave issue and the color load
    localparam int PIPE_WAIT = 8;
    localparam int WAIT_W    = $clog2(PIPE_WAIT);

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_RED   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_GREEN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_BLUE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PEAK       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP       = 3'd4;

    localparam logic [15:0] PEAK_RESET = 16'd3932;
    localparam logic [15:0] STEP_RESET = 16'd131;

    // quarter sine table, Q15, built from a second order recurrence in Q30
    localparam int QTAB_LEN = 257;
    localparam longint unsigned REC_COEF   = 64'd2147443223;
    localparam longint unsigned REC_FIRST  = 64'd6588356;
    localparam longint unsigned TWO_PI_Q24 = 64'd105414357;

    typedef logic [QTAB_LEN-1:0][14:0] t_qtab;

    function automatic t_qtab build_qtab();
        t_qtab tab;
        longint unsigned prev;
        longint unsigned cur;
        longint unsigned v;
        longint unsigned r;
        longint unsigned a;
        longint unsigned nx;
        prev = 64'd0;
        cur  = REC_FIRST;
        tab  = '0;
        for (int n = 0; n < QTAB_LEN; n++) begin
            v = (n == 0) ? 64'd0 : cur;
            r = (v + 64'd16384) >> 15;
            if (r > 64'd32767) begin
                r = 64'd32767;
            end
            tab[n] = 15'(r);
            if (n >= 1) begin
                a    = (REC_COEF * cur) >> 30;
                nx   = (a > prev) ? a - prev : 64'd0;
                prev = cur;
                cur  = nx;
            end
        end
        return tab;
    endfunction

    localparam t_qtab SINE_QTAB = build_qtab();

    // floor(2^19 / d) + 1: exact quotient of a 16-bit value by d as (u * m) >> 19
    function automatic logic [19:0] recip_q19(input logic [3:0] d);
        logic [19:0] m;
        m = '0;
        case (d)
            4'd1:    m = 20'd524289;
            4'd2:    m = 20'd262145;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131073;
            4'd5:    m = 20'd104858;
            4'd6:    m = 20'd87382;
            4'd7:    m = 20'd74899;
            4'd8:    m = 20'd65537;
            default: m = '0;
        endcase
        return m;
    endfunction

    // floor(r * 2^16 / d) for a remainder r below d
    function automatic logic [15:0] frac_q16(input logic [3:0] d, input logic [2:0] r);
        logic [15:0] f;
        f = '0;
        case (d)
            4'd2: f = {r[0], 15'd0};
            4'd3: begin
                case (r)
                    3'd1:    f = 16'd21845;
                    3'd2:    f = 16'd43690;
                    default: f = '0;
                endcase
            end
            4'd4: f = {r[1:0], 14'd0};
            4'd5: begin
                case (r)
                    3'd1:    f = 16'd13107;
                    3'd2:    f = 16'd26214;
                    3'd3:    f = 16'd39321;
                    3'd4:    f = 16'd52428;
                    default: f = '0;
                endcase
            end
            4'd6: begin
                case (r)
                    3'd1:    f = 16'd10922;
                    3'd2:    f = 16'd21845;
                    3'd3:    f = 16'd32768;
                    3'd4:    f = 16'd43690;
                    3'd5:    f = 16'd54613;
                    default: f = '0;
                endcase
            end
            4'd7: begin
                case (r)
                    3'd1:    f = 16'd9362;
                    3'd2:    f = 16'd18724;
                    3'd3:    f = 16'd28086;
                    3'd4:    f = 16'd37449;
                    3'd5:    f = 16'd46811;
                    3'd6:    f = 16'd56173;
                    default: f = '0;
                endcase
            end
            4'd8:    f = {r, 13'd0};
            default: f = '0;
        endcase
        return f;
    endfunction

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAVE,
        ST_WAIT,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic                  frame_start;
        logic                  wave_go;
        logic [WAVE_IDX_W-1:0] wave;
        logic                  led_next;
        logic                  load;
        logic [LED_IDX_W-1:0]  led;
        logic                  last;
        logic                  offset_adv;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [7:0]  base_red;
        logic [7:0]  base_green;
        logic [7:0]  base_blue;
        logic [15:0] peak_brightness;
        logic [15:0] phase_step;
    } t_cfg;

endpackage

@@ rtl/core/led_wave_animation_generator_unit.sv @@
// LED wave animation generator.
// Input channel (i_valid / o_ready): one request carries i_frame_tick. A request
// with the tick high starts a frame; one with the tick low is taken and dropped.
// Output channel (o_valid / i_ready): one request per LED, index 0 first, with
// o_last_led high on index LED_COUNT-1.
// Each LED sums WAVE_COUNT sine waves through a shared wave pipe, one wave issued
// per cycle, then a drain through the reciprocal divide and the color multiplier
// chain before its color is loaded into the output register.
// When the receiver stalls, the next LED is computed anyway and waits in the
// color registers until the output register frees up. A new frame request is
// taken while the last LED of the previous frame still waits on the output.
// Configuration writes take effect at once and belong between frames.
// Synchronous reset clears the phase offset, loads the default brightness and
// step, zeroes the base color and empties the output register.
module led_wave_animation_generator_unit
    import lwag_pkg::*;
#(
    parameter int LED_COUNT  = LED_COUNT_DEF,
    parameter int WAVE_COUNT = WAVE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_frame_tick,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [LED_IDX_W-1:0]  o_led_index,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic                  o_last_led,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_red        <= '0;
            r_cfg.base_green      <= '0;
            r_cfg.base_blue       <= '0;
            r_cfg.peak_brightness <= PEAK_RESET;
            r_cfg.phase_step      <= STEP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_BASE_RED:   r_cfg.base_red        <= i_cfg_wr_data[7:0];
                CFG_BASE_GREEN: r_cfg.base_green      <= i_cfg_wr_data[7:0];
                CFG_BASE_BLUE:  r_cfg.base_blue       <= i_cfg_wr_data[7:0];
                CFG_PEAK:       r_cfg.peak_brightness <= i_cfg_wr_data;
                CFG_STEP:       r_cfg.phase_step      <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    lwag_ctrl #(
        .LED_COUNT  (LED_COUNT),
        .WAVE_COUNT (WAVE_COUNT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_frame_tick (i_frame_tick),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    lwag_datapath #(
        .LED_COUNT  (LED_COUNT),
        .WAVE_COUNT (WAVE_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_led_index (o_led_index),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_last_led  (o_last_led)
    );

endmodule

@@ rtl/core/lwag_ctrl.sv @@
module lwag_ctrl
    import lwag_pkg::*;
#(
    parameter int LED_COUNT  = LED_COUNT_DEF,
    parameter int WAVE_COUNT = WAVE_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_frame_tick,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int KW = (WAVE_COUNT > 1) ? $clog2(WAVE_COUNT) : 1;

    t_state                r_state;
    t_state                n_state;
    logic [KW-1:0]         r_wave;
    logic [KW-1:0]         n_wave;
    logic [LED_IDX_W-1:0]  r_led;
    logic [LED_IDX_W-1:0]  n_led;
    logic [WAIT_W-1:0]     r_wait;
    logic [WAIT_W-1:0]     n_wait;
    logic                  w_last;

    assign w_last = (r_led == LED_IDX_W'(LED_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wave  <= '0;
            r_led   <= '0;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            r_wave  <= n_wave;
            r_led   <= n_led;
            r_wait  <= n_wait;
        end
    end

    always_comb begin
        n_state = r_state;
        n_wave  = r_wave;
        n_led   = r_led;
        n_wait  = r_wait;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.wave = WAVE_IDX_W'(r_wave);
        o_cmd.led  = r_led;
        o_cmd.last = w_last;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                // a request with the tick low is taken and dropped
                if (i_valid && i_frame_tick) begin
                    o_cmd.frame_start = 1'b1;
                    n_wave  = '0;
                    n_led   = '0;
                    n_state = ST_WAVE;
                end
            end
            ST_WAVE: begin
                o_cmd.wave_go = 1'b1;
                if (r_wave == KW'(WAVE_COUNT - 1)) begin
                    n_wave  = '0;
                    n_wait  = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_wave = r_wave + KW'(1);
                end
            end
            ST_WAIT: begin
                // let the wave pipe and the color pipe drain
                if (r_wait == WAIT_W'(PIPE_WAIT - 1)) begin
                    n_state = ST_LOAD;
                end else begin
                    n_wait = r_wait + WAIT_W'(1);
                end
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    if (w_last) begin
                        o_cmd.offset_adv = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.led_next = 1'b1;
                        n_led   = r_led + LED_IDX_W'(1);
                        n_state = ST_WAVE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ rtl/core/lwag_datapath.sv @@
module lwag_datapath
    import lwag_pkg::*;
#(
    parameter int LED_COUNT  = LED_COUNT_DEF,
    parameter int WAVE_COUNT = WAVE_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  t_cfg                 i_cfg,
    output t_sts                 o_sts,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [LED_IDX_W-1:0] o_led_index,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic                 o_last_led
);

    localparam int KW   = (WAVE_COUNT > 1) ? $clog2(WAVE_COUNT) : 1;
    localparam int SPAN = 100 * LED_COUNT;
    localparam int RW   = $clog2(SPAN);
    localparam int RW1  = RW + 1;
    localparam logic [21:0] X_RECIP = 22'((64'd1 << 21) / WAVE_COUNT + 64'd1);

    logic [15:0]       r_offset;
    logic [15:0]       w_lane_q [WAVE_COUNT];
    logic [15:0]       w_fix    [WAVE_COUNT];
    logic [KW-1:0]     w_wk;

    // per wave spatial phase lanes: floor(i * A_k / SPAN) kept as quotient and remainder
    for (genvar K = 0; K < WAVE_COUNT; K++) begin : g_lane
        localparam longint unsigned ANUM = 64'(30 + 21 * K) * 64'd65536;
        localparam logic [15:0]     AQ   = 16'(ANUM / SPAN);
        localparam logic [RW1-1:0]  AR   = RW1'(ANUM % SPAN);
        localparam longint unsigned FIXV = ((64'(K) * TWO_PI_Q24) / WAVE_COUNT + 64'd128) >> 8;

        logic [15:0]    r_sq;
        logic [RW-1:0]  r_sr;
        logic [RW1-1:0] w_rsum;

        assign w_rsum      = {1'b0, r_sr} + AR;
        assign w_lane_q[K] = r_sq;
        assign w_fix[K]    = 16'(FIXV);

        always_ff @(posedge i_clk) begin
            if (i_cmd.frame_start) begin
                r_sq <= '0;
                r_sr <= '0;
            end else if (i_cmd.led_next) begin
                if (w_rsum >= RW1'(SPAN)) begin
                    r_sr <= RW'(w_rsum - RW1'(SPAN));
                    r_sq <= r_sq + AQ + 16'd1;
                end else begin
                    r_sr <= RW'(w_rsum);
                    r_sq <= r_sq + AQ;
                end
            end
        end
    end

    // wave stage 0: phase, sine lookup, offset to unsigned
    logic [15:0] w_phase;
    logic [9:0]  w_idx;
    logic [8:0]  w_half;
    logic [8:0]  w_qi;
    logic [14:0] w_mag;
    logic [15:0] w_u;

    assign w_wk    = i_cmd.wave[KW-1:0];
    assign w_phase = w_lane_q[w_wk] + r_offset + w_fix[w_wk];
    assign w_idx   = w_phase[15:6];
    assign w_half  = w_idx[8:0];
    assign w_qi    = (w_half > 9'd256) ? 9'(10'd512 - {1'b0, w_half}) : w_half;
    assign w_mag   = SINE_QTAB[w_qi];
    assign w_u     = w_idx[9] ? 16'(17'd32768 - {2'b0, w_mag})
                              : 16'(17'd32768 + {2'b0, w_mag});

    logic        r_v0;
    logic        r_v1;
    logic        r_v2;
    logic [15:0] r_u0;
    logic [3:0]  r_d0;
    logic [15:0] r_u1;
    logic [3:0]  r_d1;
    logic [15:0] r_q1;
    logic [3:0]  r_d2;
    logic [15:0] r_q2;
    logic [2:0]  r_rem;
    logic [19:0] w_recip;
    logic [35:0] w_qprod;
    logic [19:0] w_qd;
    logic [19:0] w_rem;
    logic [15:0] w_frac;
    logic [SUM_W-1:0] r_sum;

    // stage 1: u / d by reciprocal, stage 2: remainder, stage 3: accumulate
    assign w_recip = recip_q19(r_d0);
    assign w_qprod = r_u0 * w_recip;
    assign w_qd    = r_q1 * r_d1;
    assign w_rem   = {4'b0, r_u1} - w_qd;
    assign w_frac  = frac_q16(r_d2, r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.wave_go;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u0  <= w_u;
        r_d0  <= 4'(w_wk) + 4'd1;
        r_u1  <= r_u0;
        r_d1  <= r_d0;
        r_q1  <= w_qprod[34:19];
        r_d2  <= r_d1;
        r_q2  <= r_q1;
        r_rem <= w_rem[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_start || i_cmd.led_next) begin
            r_sum <= '0;
        end else if (r_v2) begin
            r_sum <= r_sum + SUM_W'({r_q2, w_frac});
        end
    end

    // color pipe, free running behind the sum
    logic [17:0] w_y;
    logic [39:0] w_xprod;
    logic [15:0] r_x;
    logic [15:0] r_x_d;
    logic [31:0] w_sq;
    logic [15:0] r_x2;
    logic [17:0] w_poly;
    logic [33:0] w_ssprod;
    logic [16:0] r_ss;
    logic [32:0] r_scale;
    logic [40:0] w_ch_r;
    logic [40:0] w_ch_g;
    logic [40:0] w_ch_b;
    logic [7:0]  r_ch_r;
    logic [7:0]  r_ch_g;
    logic [7:0]  r_ch_b;

    assign w_y      = r_sum[SUM_W-1:16];
    assign w_xprod  = w_y * X_RECIP;
    assign w_sq     = r_x * r_x;
    assign w_poly   = 18'd196608 - {1'b0, r_x_d, 1'b0};
    assign w_ssprod = r_x2 * w_poly;
    assign w_ch_r   = i_cfg.base_red * r_scale;
    assign w_ch_g   = i_cfg.base_green * r_scale;
    assign w_ch_b   = i_cfg.base_blue * r_scale;

    always_ff @(posedge i_clk) begin
        // quotient above 16 bits saturates
        r_x     <= (|w_xprod[39:37]) ? 16'hFFFF : w_xprod[36:21];
        r_x_d   <= r_x;
        r_x2    <= w_sq[31:16];
        r_ss    <= w_ssprod[32:16];
        r_scale <= r_ss * i_cfg.peak_brightness;
        r_ch_r  <= w_ch_r[39:32];
        r_ch_g  <= w_ch_g[39:32];
        r_ch_b  <= w_ch_b[39:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cmd.offset_adv) begin
            r_offset <= r_offset + i_cfg.phase_step;
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_led_index <= i_cmd.led;
            o_red       <= r_ch_r;
            o_green     <= r_ch_g;
            o_blue      <= r_ch_b;
            o_last_led  <= i_cmd.last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sts.out_free = !r_out_valid || i_ready;

endmodule

@@ tb/sv/tb_led_wave_animation_generator_unit.sv @@
module tb_led_wave_animation_generator_unit;
    import lwag_pkg::*;

    localparam int LED_N           = LED_COUNT_DEF;
    localparam int WAVE_N          = WAVE_COUNT_DEF;
    localparam int DRAIN_CYCLES    = 32;
    localparam int STALL_LIMIT     = 20000;
    localparam int PRESSURE_CYCLES = 3000;

    localparam longint unsigned SINE_REC_MUL  = 64'd2147443223;
    localparam longint unsigned SINE_REC_SEED = 64'd6588356;
    localparam longint unsigned TURN_Q24      = 64'd105414357;

    // indexes past the last register, writes there must do nothing
    localparam logic [CFG_ADDR_W-1:0] CFG_NONE_LO  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_NONE_MID = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_NONE_HI  = 3'd7;

    typedef struct packed {
        logic [LED_IDX_W-1:0] led_index;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic                 last_led;
    } led_color_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_FRAME
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
        logic                  tick;
        logic                  dark;
    } stim_row_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  i_frame_tick  = 1'b0;
    logic                  i_ready       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data = '0;
    logic                  o_ready;
    logic                  o_valid;
    logic [LED_IDX_W-1:0]  o_led_index;
    logic [7:0]            o_red;
    logic [7:0]            o_green;
    logic [7:0]            o_blue;
    logic                  o_last_led;

    // mirror of the block's registers and phase accumulator
    logic [7:0]  base_red        = 8'd0;
    logic [7:0]  base_green      = 8'd0;
    logic [7:0]  base_blue       = 8'd0;
    logic [15:0] peak_brightness = PEAK_RESET;
    logic [15:0] phase_step      = STEP_RESET;
    logic [15:0] phase_offset    = 16'd0;

    int          quarter_sine [0:QTAB_LEN-1];
    led_color_t  pending_colors [$];
    stim_row_t   directed_rows [$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic pressure_req   = 1'b0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;

    int frames_sent    = 0;
    int ticks_dropped  = 0;
    int reg_writes     = 0;
    int colors_checked = 0;
    int mismatches     = 0;

    led_wave_animation_generator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_frame_tick  (i_frame_tick),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_led_index   (o_led_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_last_led    (o_last_led),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // quarter wave in Q30 by the second order recurrence, rounded to Q15
    function automatic void build_quarter_sine();
        longint unsigned prev;
        longint unsigned cur;
        longint unsigned v;
        longint unsigned r;
        longint unsigned a;
        prev = 64'd0;
        cur  = SINE_REC_SEED;
        for (int n = 0; n < QTAB_LEN; n++) begin
            v = (n == 0) ? 64'd0 : cur;
            r = (v + 64'd16384) >> 15;
            if (r > 64'd32767) begin
                r = 64'd32767;
            end
            quarter_sine[n] = int'(r);
            if (n >= 1) begin
                a    = (SINE_REC_MUL * cur) >> 30;
                r    = (a > prev) ? a - prev : 64'd0;
                prev = cur;
                cur  = r;
            end
        end
    endfunction

    function automatic int sine_at(input logic [9:0] idx);
        int          v;
        logic [8:0]  h;
        h = idx[8:0];
        v = (h <= 9'd256) ? quarter_sine[h] : quarter_sine[10'd512 - h];
        return idx[9] ? -v : v;
    endfunction

    // queues the colors of one frame and advances the phase
    function automatic void predict_frame(input logic dark);
        longint unsigned spatial;
        longint unsigned fixed_ph;
        longint unsigned ph;
        longint unsigned u;
        longint unsigned sum;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned ss;
        longint unsigned scale;
        led_color_t      c;
        for (int i = 0; i < LED_N; i++) begin
            sum = 64'd0;
            for (int k = 0; k < WAVE_N; k++) begin
                spatial  = (64'(i) * 64'(30 + 21 * k) * 64'd65536) / (64'd100 * 64'(LED_N));
                fixed_ph = ((64'(k) * TURN_Q24) / 64'(WAVE_N) + 64'd128) >> 8;
                ph       = (spatial + 64'(phase_offset) + fixed_ph) & 64'hFFFF;
                u        = 64'(sine_at(ph[15:6]) + 32768);
                sum      = sum + (u << 16) / 64'(k + 1);
            end
            x = (sum / (64'd2 * 64'(WAVE_N))) >> 15;
            if (x > 64'd65535) begin
                x = 64'd65535;
            end
            x2    = (x * x) >> 16;
            ss    = (x2 * (64'd196608 - 64'd2 * x)) >> 16;
            scale = ss * 64'(peak_brightness);
            c.led_index = LED_IDX_W'(i);
            c.red       = 8'((64'(base_red) * scale) >> 32);
            c.green     = 8'((64'(base_green) * scale) >> 32);
            c.blue      = 8'((64'(base_blue) * scale) >> 32);
            c.last_led  = (i == LED_N - 1);
            if (dark) begin
                c.red   = 8'd0;
                c.green = 8'd0;
                c.blue  = 8'd0;
            end
            pending_colors.push_back(c);
        end
        phase_offset = phase_offset + phase_step;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [CFG_DATA_W-1:0] data, input logic tick,
                                    input logic dark);
        stim_row_t r;
        r.kind = kind;
        r.addr = addr;
        r.data = data;
        r.tick = tick;
        r.dark = dark;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(3))
            0:       v = '0;
            1:       v = '1;
            default: v = CFG_DATA_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= addr;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (addr)
            CFG_BASE_RED:   base_red        = data[7:0];
            CFG_BASE_GREEN: base_green      = data[7:0];
            CFG_BASE_BLUE:  base_blue       = data[7:0];
            CFG_PEAK:       peak_brightness = data;
            CFG_STEP:       phase_step      = data;
            default:        ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // valid stays up across back to back requests, dropped only for a gap
    task automatic send_request(input logic tick, input logic dark);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_frame_tick <= tick;
        do @(posedge i_clk); while (!o_ready);
        if (tick) begin
            predict_frame(dark);
            frames_sent++;
        end else begin
            ticks_dropped++;
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_colors.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic shuffle_config();
        write_reg(CFG_BASE_RED, pick_reg_value());
        write_reg(CFG_BASE_GREEN, pick_reg_value());
        write_reg(CFG_BASE_BLUE, pick_reg_value());
        write_reg(CFG_PEAK, pick_reg_value());
        write_reg(CFG_STEP, pick_reg_value());
        if ($urandom_range(1) == 0) begin
            write_reg(CFG_ADDR_W'($urandom_range(CFG_NONE_LO, CFG_NONE_HI)), pick_reg_value());
        end
    endtask

    task automatic run_phase(input int send_pct, input int stall_pct, input int n_ticks,
                             input bit pressure);
        int   ticks;
        logic tick;
        wait_drained();
        shuffle_config();
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        if (pressure) begin
            pressure_req <= 1'b1;
            @(posedge i_clk);
            pressure_req <= 1'b0;
        end
        ticks = 0;
        while (ticks < n_ticks) begin
            tick = ($urandom_range(9) != 0);
            send_request(tick, 1'b0);
            if (tick) begin
                ticks++;
            end
        end
        wait_drained();
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (pressure_req) begin
            hold_left <= PRESSURE_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        if (!i_rst_n || pressure_req || hold_left != 0) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : color_check
        led_color_t got;
        led_color_t want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_led_index, o_red, o_green, o_blue, o_last_led};
            if (pending_colors.size() == 0) begin
                mismatches++;
                $display("%0t: color with nothing pending, led %0d rgb %0d/%0d/%0d last %0b",
                         $time, o_led_index, o_red, o_green, o_blue, o_last_led);
            end else begin
                want = pending_colors.pop_front();
                colors_checked++;
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: expected led %0d rgb %0d/%0d/%0d last %0b, got led %0d rgb %0d/%0d/%0d last %0b",
                             $time, want.led_index, want.red, want.green, want.blue,
                             want.last_led, got.led_index, got.red, got.green, got.blue,
                             got.last_led);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        build_quarter_sine();

        // reset colors are black; peak of zero or a black base gives dark frames
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b1);
        add_row(ROW_FRAME, '0, '0, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_BASE_RED, 16'd255, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_BASE_GREEN, 16'd255, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_BASE_BLUE, 16'd255, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_PEAK, 16'hFFFF, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_STEP, 16'h0000, 1'b0, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b0);
        add_row(ROW_WRITE, CFG_STEP, 16'hFFFF, 1'b0, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b0);
        add_row(ROW_WRITE, CFG_PEAK, 16'h0000, 1'b0, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b1);
        // writes past the register map must leave the dark setting alone
        add_row(ROW_WRITE, CFG_NONE_LO, 16'hFFFF, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_NONE_MID, 16'hFFFF, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_NONE_HI, 16'hFFFF, 1'b0, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b1);
        // upper data bits must be dropped on the color registers
        add_row(ROW_WRITE, CFG_BASE_RED, 16'hAB80, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_BASE_GREEN, 16'h0101, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_BASE_BLUE, 16'hFF00, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_PEAK, 16'h8000, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_STEP, 16'h8000, 1'b0, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b0, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b0);
        add_row(ROW_WRITE, CFG_BASE_RED, 16'd0, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_BASE_GREEN, 16'd0, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_BASE_BLUE, 16'd0, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_PEAK, 16'hFFFF, 1'b0, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b1);
        add_row(ROW_WRITE, CFG_BASE_RED, 16'd200, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_BASE_GREEN, 16'd100, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_BASE_BLUE, 16'd50, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_PEAK, PEAK_RESET, 1'b0, 1'b0);
        add_row(ROW_WRITE, CFG_STEP, STEP_RESET, 1'b0, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b0);
        add_row(ROW_FRAME, '0, '0, 1'b1, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(directed_rows[n].addr, directed_rows[n].data);
            end else begin
                send_request(directed_rows[n].tick, directed_rows[n].dark);
            end
        end

        run_phase(0, 0, 19, 1'b0);
        run_phase(48, 0, 19, 1'b0);
        run_phase(0, 48, 19, 1'b0);
        run_phase(16, 16, 19, 1'b0);
        run_phase(0, 16, 8, 1'b1);

        $display("run covered %0d frames, %0d dropped ticks and %0d register writes",
                 frames_sent, ticks_dropped, reg_writes);
        $display("%0d led colors checked with %0d mismatches", colors_checked, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lwag_pkg.sv
rtl/core/lwag_ctrl.sv
rtl/core/lwag_datapath.sv
rtl/core/led_wave_animation_generator_unit.sv
tb/sv/tb_led_wave_animation_generator_unit.sv
